// File: src/itd_pkg.sv
// Shared constants, types and the key hash for the index tuple dedup block.
package itd_pkg;

	// Table size and index widths
	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
	localparam int ID_BITS     = 12;
	localparam int FIELD_BITS  = 20;
	localparam int INDEX_BITS  = 20;
	localparam int KEY_BITS    = 3 * INDEX_BITS;
	localparam int CNT_BITS    = ADDR_BITS + 1;

	// Epoch tags: zero marks a slot that is never valid
	localparam int EPOCH_BITS = 4;
	localparam logic [EPOCH_BITS-1:0] EPOCH_NONE  = '0;
	localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
	localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

	// Opcodes
	localparam logic OP_CORNER = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// Key modes
	localparam logic MODE_TWO_INDEX   = 1'b0;
	localparam logic MODE_THREE_INDEX = 1'b1;

	localparam int HASH_CHUNKS = (KEY_BITS + ADDR_BITS - 1) / ADDR_BITS;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [ADDR_BITS-1:0]  addr_t;
	typedef logic [INDEX_BITS-1:0] index_t;

	// One hash slot: epoch tag, stored key and the unified id it maps to
	typedef struct packed {
		logic [EPOCH_BITS-1:0] epoch;
		key_t                  key;
		logic [ID_BITS-1:0]    id;
	} slot_t;

	// XOR fold of the key down to a slot address
	function automatic addr_t hash_key(input key_t k);
		logic [HASH_CHUNKS*ADDR_BITS-1:0] kp;
		addr_t                            h;
		kp = (HASH_CHUNKS*ADDR_BITS)'(k);
		h  = '0;
		for (int c = 0; c < HASH_CHUNKS; c++) begin
			h = h ^ kp[c*ADDR_BITS +: ADDR_BITS];
		end
		return h;
	endfunction

endpackage

// File: src/itd_if.sv
// Handshake interfaces for corners, results and the key mode register.
interface itd_corner_if
	import itd_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [FIELD_BITS-1:0] pos_index;
	logic [FIELD_BITS-1:0] tex_index;
	logic [FIELD_BITS-1:0] nrm_index;
	logic                  last_corner;

	modport source (output valid, opcode, pos_index, tex_index, nrm_index, last_corner,
		input ready);
	modport sink (input valid, opcode, pos_index, tex_index, nrm_index, last_corner,
		output ready);
endinterface

interface itd_result_if
	import itd_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [ID_BITS-1:0]    unified_id;
	logic                  is_new;
	logic [FIELD_BITS-1:0] new_pos_index;
	logic [FIELD_BITS-1:0] new_tex_index;
	logic [FIELD_BITS-1:0] new_nrm_index;
	logic                  poly_end;
	logic                  overflow;

	modport source (output valid, unified_id, is_new, new_pos_index, new_tex_index,
		new_nrm_index, poly_end, overflow, input ready);
	modport sink (input valid, unified_id, is_new, new_pos_index, new_tex_index,
		new_nrm_index, poly_end, overflow, output ready);
endinterface

interface itd_cfg_if;
	logic valid;
	logic ready;
	logic key_mode;

	modport source (output valid, key_mode, input ready);
	modport sink (input valid, key_mode, output ready);
endinterface

// File: src/index_tuple_dedup.sv
// Vertex index tuple dedup: hashed key table with a probe sequencer.
//
// Each corner transaction is looked up in a 4096-slot hash table held in one
// single-port-write, registered-read memory, probed by linear probing with one
// shared key comparator. A corner whose key hits in the first slot passes
// from acceptance to result through accept, read, compare and result load;
// each further probe adds a memory read and compare, up to 4096 probes
// when the table is full and the key is new. Ids are handed out in order of
// first sight. A clear transaction bumps an epoch tag, so no slot has to be
// touched; after reset, and on every 15th clear when the tag wraps, a
// clearing pass writes all 4096 slots, one per cycle, and no corner is
// accepted during the pass. The key mode register may be written at any
// time the block is idle and is always ready. The result register lets the
// next corner be accepted while a result waits.
module index_tuple_dedup
	import itd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	itd_corner_if.sink    corner,
	itd_result_if.source  result,
	itd_cfg_if.sink       cfg
);

	// Sequencer states
	localparam logic [2:0] ST_SWEEP = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_CMP   = 3'd3;
	localparam logic [2:0] ST_PUSH  = 3'd4;

	logic [2:0]            state_q;
	logic                  key_mode_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic [CNT_BITS-1:0]   next_id_q;
	addr_t                 probe_q;
	addr_t                 probe_cnt_q;
	key_t                  key_q;
	index_t                pos_q;
	index_t                tex_q;
	index_t                nrm_q;
	logic                  last_q;
	logic [ID_BITS-1:0]    res_id_q;
	logic                  res_new_q;
	logic                  res_ovf_q;

	// Output register
	logic                  out_valid_q;
	logic [ID_BITS-1:0]    out_id_q;
	logic                  out_new_q;
	logic [FIELD_BITS-1:0] out_pos_q;
	logic [FIELD_BITS-1:0] out_tex_q;
	logic [FIELD_BITS-1:0] out_nrm_q;
	logic                  out_end_q;
	logic                  out_ovf_q;

	// Slot memory
	slot_t                 slot_mem_q [TABLE_DEPTH];
	slot_t                 rd_slot_q;
	logic                  wr_en;
	slot_t                 wr_slot;

	logic                  in_fire;
	logic                  out_load;
	index_t                in_pos;
	index_t                in_tex;
	index_t                in_nrm;
	key_t                  in_key;
	logic                  slot_live;
	logic                  slot_hit;
	logic                  table_full;

	// Input side
	assign corner.ready = (state_q == ST_IDLE);
	assign in_fire      = corner.valid && corner.ready;
	assign cfg.ready    = 1'b1;

	assign in_pos = corner.pos_index[INDEX_BITS-1:0];
	assign in_tex = corner.tex_index[INDEX_BITS-1:0];
	assign in_nrm = (key_mode_q == MODE_THREE_INDEX) ? corner.nrm_index[INDEX_BITS-1:0] : '0;
	assign in_key = {in_nrm, in_tex, in_pos};

	// Probe compare
	assign slot_live  = (rd_slot_q.epoch == epoch_q);
	assign slot_hit   = slot_live && (rd_slot_q.key == key_q);
	assign table_full = (next_id_q == CNT_BITS'(TABLE_DEPTH));

	// Result register loads when free or being drained
	assign out_load = (state_q == ST_PUSH) && (!out_valid_q || result.ready);

	// Memory write: clearing pass or insert of a new key
	always_comb begin
		wr_en   = 1'b0;
		wr_slot = '0;
		if (state_q == ST_SWEEP) begin
			wr_en         = 1'b1;
			wr_slot.epoch = EPOCH_NONE;
		end else if (state_q == ST_CMP && !slot_live && !table_full) begin
			wr_en         = 1'b1;
			wr_slot.epoch = epoch_q;
			wr_slot.key   = key_q;
			wr_slot.id    = next_id_q[ID_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem_q[probe_q] <= wr_slot;
		end
		rd_slot_q <= slot_mem_q[probe_q];
	end

	// Key mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mode_q <= MODE_TWO_INDEX;
		end else if (cfg.valid && cfg.ready) begin
			key_mode_q <= cfg.key_mode;
		end
	end

	// Probe sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			epoch_q     <= EPOCH_FIRST;
			next_id_q   <= '0;
			probe_q     <= '0;
			probe_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					probe_q <= probe_q + addr_t'(1);
					if (probe_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						if (corner.opcode == OP_CLEAR) begin
							next_id_q <= '0;
							if (epoch_q == EPOCH_LAST) begin
								epoch_q <= EPOCH_FIRST;
								probe_q <= '0;
								state_q <= ST_SWEEP;
							end else begin
								epoch_q <= epoch_q + EPOCH_BITS'(1);
							end
						end else begin
							probe_q     <= hash_key(in_key);
							probe_cnt_q <= '0;
							state_q     <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (slot_hit || !slot_live || probe_cnt_q == '1) begin
						state_q <= ST_PUSH;
						if (!slot_hit && !slot_live && !table_full) begin
							next_id_q <= next_id_q + CNT_BITS'(1);
						end
					end else begin
						probe_q     <= probe_q + addr_t'(1);
						probe_cnt_q <= probe_cnt_q + addr_t'(1);
						state_q     <= ST_READ;
					end
				end
				ST_PUSH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Corner payload and lookup outcome
	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q  <= in_key;
			pos_q  <= in_pos;
			tex_q  <= in_tex;
			nrm_q  <= in_nrm;
			last_q <= corner.last_corner;
		end
		if (state_q == ST_CMP) begin
			if (slot_hit) begin
				res_id_q  <= rd_slot_q.id;
				res_new_q <= 1'b0;
				res_ovf_q <= 1'b0;
			end else if (!slot_live && !table_full) begin
				res_id_q  <= next_id_q[ID_BITS-1:0];
				res_new_q <= 1'b1;
				res_ovf_q <= 1'b0;
			end else begin
				res_id_q  <= '0;
				res_new_q <= 1'b0;
				res_ovf_q <= 1'b1;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_id_q  <= res_id_q;
			out_new_q <= res_new_q;
			out_pos_q <= FIELD_BITS'(pos_q);
			out_tex_q <= FIELD_BITS'(tex_q);
			out_nrm_q <= FIELD_BITS'(nrm_q);
			out_end_q <= last_q;
			out_ovf_q <= res_ovf_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.unified_id    = out_id_q;
	assign result.is_new        = out_new_q;
	assign result.new_pos_index = out_pos_q;
	assign result.new_tex_index = out_tex_q;
	assign result.new_nrm_index = out_nrm_q;
	assign result.poly_end      = out_end_q;
	assign result.overflow      = out_ovf_q;

	// Checks
	a_next_id_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q <= CNT_BITS'(TABLE_DEPTH))
		else $error("next id ran past the table depth");

	a_new_ovf_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_new_q && out_ovf_q))
		else $error("result is both new and overflow");

	a_ovf_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ovf_q) |-> (out_id_q == '0))
		else $error("overflow result carries a nonzero id");

	a_clear_resets_id: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && corner.opcode == OP_CLEAR) |=> (next_id_q == '0))
		else $error("clear did not reset the id counter");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_SWEEP || state_q == ST_CMP))
		else $error("slot memory written outside sweep or insert");

endmodule

// File: verif/itd_checker.sv
// Checker for index_tuple_dedup: predicts each corner's result and compares it.
`timescale 1ns / 100ps

module itd_checker
	import itd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	itd_corner_if corner,
	itd_result_if result,
	itd_cfg_if    cfg,
	output int    fail_count,
	output int    pending
);

	// What one corner should come back as
	typedef struct packed {
		logic [ID_BITS-1:0]    unified_id;
		logic                  is_new;
		logic [FIELD_BITS-1:0] pos;
		logic [FIELD_BITS-1:0] tex;
		logic [FIELD_BITS-1:0] nrm;
		logic                  poly_end;
		logic                  overflow;
	} corner_result_t;

	corner_result_t results_due[$];
	key_t           seen_keys[TABLE_DEPTH];   // key of each id handed out so far
	int             ids_issued;               // ids in use since the last clear
	logic           key_mode_q;

	function automatic bit field_differs(string name, int unsigned want, int unsigned got);
		if (want == got) return 1'b0;
		$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		corner_result_t want;
		key_t           key;
		int             hit_id;
		int             bad;
		if (!arst_n) begin
			results_due.delete();
			ids_issued = 0;
			key_mode_q = MODE_TWO_INDEX;
			fail_count = 0;
			pending    <= 0;
		end else begin
			// key mode register write
			if (cfg.valid && cfg.ready) begin
				key_mode_q = cfg.key_mode;
			end

			// outgoing result against the oldest expectation
			if (result.valid && result.ready) begin
				if (results_due.size() == 0) begin
					$error("result transaction with no corner pending: unified_id 0x%0h",
						result.unified_id);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					bad  = 0;
					bad += field_differs("unified_id", want.unified_id, result.unified_id);
					bad += field_differs("is_new", want.is_new, result.is_new);
					bad += field_differs("new_pos_index", want.pos, result.new_pos_index);
					bad += field_differs("new_tex_index", want.tex, result.new_tex_index);
					bad += field_differs("new_nrm_index", want.nrm, result.new_nrm_index);
					bad += field_differs("poly_end", want.poly_end, result.poly_end);
					bad += field_differs("overflow", want.overflow, result.overflow);
					if (bad != 0) fail_count++;
				end
			end

			// incoming corner: look the key up, insert it if unseen
			if (corner.valid && corner.ready) begin
				if (corner.opcode == OP_CLEAR) begin
					ids_issued = 0;
				end else begin
					want.pos      = corner.pos_index;
					want.tex      = corner.tex_index;
					want.nrm      = (key_mode_q == MODE_THREE_INDEX) ? corner.nrm_index : '0;
					want.poly_end = corner.last_corner;
					key           = {want.nrm, want.tex, want.pos};
					hit_id        = -1;
					for (int i = 0; i < ids_issued; i++) begin
						if (seen_keys[i] == key) begin
							hit_id = i;
							break;
						end
					end
					want.unified_id = '0;
					want.is_new     = 1'b0;
					want.overflow   = 1'b0;
					if (hit_id >= 0) begin
						want.unified_id = ID_BITS'(hit_id);
					end else if (ids_issued < TABLE_DEPTH) begin
						seen_keys[ids_issued] = key;
						want.unified_id       = ID_BITS'(ids_issued);
						want.is_new           = 1'b1;
						ids_issued++;
					end else begin
						// table full, key unseen
						want.overflow = 1'b1;
					end
					results_due = {results_due, want};
				end
			end

			pending <= results_due.size();
		end
	end

endmodule

// File: verif/tb.sv
// Testbench top for index_tuple_dedup: clock, reset, corner stimulus and verdict.
`timescale 1ns / 100ps

module tb;
	import itd_pkg::*;

	localparam int POOL_SIZE    = 16;
	localparam int PHASE_ITEMS  = 500;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 100;   // covers a clearing pass
	localparam int MAX_OCCUPANCY = 200;

	logic clk = 1'b0;
	logic arst_n;

	int send_idle_pct;
	int stall_pct;
	int since_clear;
	int chk_fails;
	int chk_pending;

	logic [FIELD_BITS-1:0] pool_pos[POOL_SIZE];
	logic [FIELD_BITS-1:0] pool_tex[POOL_SIZE];
	logic [FIELD_BITS-1:0] pool_nrm[POOL_SIZE];

	itd_corner_if corner_ch ();
	itd_result_if result_ch ();
	itd_cfg_if    cfg_ch ();

	index_tuple_dedup u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.corner (corner_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	itd_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.corner     (corner_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.fail_count (chk_fails),
		.pending    (chk_pending)
	);

	always #2 clk = ~clk;

	// result side back-pressure
	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// run limit
	initial begin
		#40_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// index values weighted toward the edges of the range
	function automatic logic [FIELD_BITS-1:0] pick_index();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return FIELD_BITS'($urandom_range(15));
			default: return FIELD_BITS'($urandom);
		endcase
	endfunction

	// one corner or clear transaction, with an optional idle gap in front
	task automatic send_item(input logic op, input logic [FIELD_BITS-1:0] pos,
		input logic [FIELD_BITS-1:0] tex, input logic [FIELD_BITS-1:0] nrm,
		input logic last);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
		if (gap > 0) begin
			corner_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		corner_ch.valid       <= 1'b1;
		corner_ch.opcode      <= op;
		corner_ch.pos_index   <= pos;
		corner_ch.tex_index   <= tex;
		corner_ch.nrm_index   <= nrm;
		corner_ch.last_corner <= last;
		do @(posedge clk); while (!corner_ch.ready);
		since_clear = (op == OP_CLEAR) ? 0 : since_clear + 1;
	endtask

	task automatic send_clear();
		send_item(OP_CLEAR, pick_index(), pick_index(), pick_index(), 1'($urandom_range(1)));
	endtask

	// hold corners back until every result is out
	task automatic drain_results();
		corner_ch.valid <= 1'b0;
		do @(posedge clk); while (chk_pending != 0);
	endtask

	task automatic write_key_mode(input logic mode);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid    <= 1'b1;
		cfg_ch.key_mode <= mode;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// one polygon drawn mostly from a small pool of tuples so keys repeat;
	// some polygons get ragged end marks or are cut short by a clear
	task automatic send_polygon(output int sent);
		int   n;
		int   slot;
		logic ragged;
		logic [FIELD_BITS-1:0] nrm;
		n      = $urandom_range(6, 3);
		ragged = ($urandom_range(9) == 0);
		sent   = 0;
		for (int k = 0; k < n; k++) begin
			slot = $urandom_range(POOL_SIZE - 1);
			if ($urandom_range(99) < 45) begin
				pool_pos[slot] = pick_index();
				pool_tex[slot] = pick_index();
				pool_nrm[slot] = pick_index();
			end
			nrm = pool_nrm[slot];
			// same position and texture, other normal
			if ($urandom_range(3) == 0) nrm = pick_index();
			send_item(OP_CORNER, pool_pos[slot], pool_tex[slot], nrm,
				ragged ? 1'($urandom_range(1)) : (k == n - 1));
			sent++;
			if (ragged && $urandom_range(7) == 0) begin
				send_clear();
				sent++;
				break;
			end
		end
	endtask

	initial begin : stimulus
		logic mode;
		int   phase_sent;
		int   sent;
		logic paused;
		arst_n                = 1'b0;
		corner_ch.valid       = 1'b0;
		corner_ch.opcode      = OP_CORNER;
		corner_ch.pos_index   = '0;
		corner_ch.tex_index   = '0;
		corner_ch.nrm_index   = '0;
		corner_ch.last_corner = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.key_mode       = MODE_TWO_INDEX;
		send_idle_pct         = 0;
		stall_pct             = 0;
		since_clear           = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// two-index keys: normal index ignored and echoed as zero
		write_key_mode(MODE_TWO_INDEX);
		send_item(OP_CORNER, '0, '0, '0, 1'b0);
		send_item(OP_CORNER, '1, '1, '1, 1'b1);
		send_item(OP_CORNER, '0, '0, 20'h12345, 1'b0);
		send_item(OP_CORNER, '1, '1, '0, 1'b1);
		send_item(OP_CORNER, 20'h1, '0, '0, 1'b0);
		send_item(OP_CORNER, '0, 20'h1, '0, 1'b0);
		send_item(OP_CORNER, 20'h80000, 20'h7FFFF, 20'hAAAAA, 1'b1);
		send_item(OP_CORNER, 20'h1, '0, '1, 1'b1);
		send_item(OP_CLEAR, '1, '1, '1, 1'b1);
		send_item(OP_CORNER, '1, '1, '0, 1'b0);
		send_item(OP_CORNER, 20'h7FFFF, 20'h80000, '0, 1'b1);

		// switch to three-index keys without a clear: old keys match normal 0
		write_key_mode(MODE_THREE_INDEX);
		send_item(OP_CORNER, '1, '1, '0, 1'b0);
		send_item(OP_CORNER, '1, '1, 20'h1, 1'b0);
		send_item(OP_CORNER, '1, '1, '1, 1'b1);
		send_item(OP_CORNER, 20'h5, 20'h6, '1, 1'b0);
		send_item(OP_CORNER, 20'h5, 20'h6, '1, 1'b1);
		send_item(OP_CORNER, 20'h5, 20'h6, 20'h7FFFF, 1'b0);
		send_item(OP_CLEAR, '0, '0, '0, 1'b0);
		send_item(OP_CORNER, 20'h5, 20'h6, '1, 1'b1);

		// fill the table with keys that land in distinct slots, then overflow
		send_item(OP_CLEAR, '0, '0, '0, 1'b0);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			send_item(OP_CORNER, FIELD_BITS'(i), '0, '0, (i % 4) == 3);
		end
		send_item(OP_CORNER, '1, 20'h1, '0, 1'b0);
		send_item(OP_CORNER, '0, '0, '0, 1'b1);
		send_item(OP_CORNER, FIELD_BITS'(TABLE_DEPTH - 1), '0, '0, 1'b0);
		send_item(OP_CORNER, '0, '0, 20'h1, 1'b1);
		send_item(OP_CLEAR, '1, '1, '1, 1'b1);
		send_item(OP_CORNER, 20'h7, 20'h7, 20'h7, 1'b1);

		// random polygons under each idling pattern
		for (int s = 0; s < POOL_SIZE; s++) begin
			pool_pos[s] = pick_index();
			pool_tex[s] = pick_index();
			pool_nrm[s] = pick_index();
		end
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					mode = MODE_THREE_INDEX;
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					mode = MODE_TWO_INDEX;
					send_idle_pct = 67;
					stall_pct = 0;
				end
				2: begin
					mode = MODE_THREE_INDEX;
					send_idle_pct = 0;
					stall_pct = 67;
				end
				default: begin
					mode = MODE_TWO_INDEX;
					send_idle_pct = 10;
					stall_pct = 10;
				end
			endcase
			write_key_mode(mode);
			phase_sent = 0;
			paused     = 1'b0;
			while (phase_sent < PHASE_ITEMS) begin
				if (!paused && phase_sent >= PHASE_ITEMS / 2) begin
					drain_results();
					paused = 1'b1;
				end
				if (since_clear > MAX_OCCUPANCY || $urandom_range(99) < 4) begin
					send_clear();
					phase_sent++;
				end else begin
					send_polygon(sent);
					phase_sent += sent;
				end
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (chk_fails == 0 && chk_pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
